[sv/hdlc_enc_pkg.sv]
// ---------------------------------------------------------------------------
// HDLC encoder package
// Shared types, constants and the CRC-16 byte update for the frame encoder.
// ---------------------------------------------------------------------------
package hdlc_enc_pkg;

   localparam logic [7:0]  HDLC_FLAG        = 8'h7E;
   localparam logic [15:0] CRC_INIT         = 16'hFFFF;
   localparam logic [15:0] CRC_POLY         = 16'h8408;
   localparam logic [2:0]  STUFF_LIMIT      = 3'd5;
   localparam int          HDLC_QUEUE_DEPTH = 4;

   // One byte-wide unit of line work handed from the front to the back
   typedef struct packed {
      logic [7:0] data;        // bits sent LSB first
      logic       is_flag;     // flag byte: no stuffing, run count untouched
      logic       reset_line;  // clear run count and set line level before bit 0
      logic       end_mark;    // last bit of this unit ends the item
   } seg_type;

   typedef enum logic [2:0] {
      FS_IDLE,
      FS_OPEN,
      FS_DATA,
      FS_FCS_LO,
      FS_FCS_HI,
      FS_CLOSE
   } front_state_type;

   // Reflected CRC-16 update by one byte, LSB first
   function automatic logic [15:0] crc_byte(input logic [15:0] crc, input logic [7:0] v);
      logic [15:0] c;
      c = crc ^ {8'h00, v};
      for (int j = 0; j < 8; j++) begin
         if (c[0]) begin
            c = (c >> 1) ^ CRC_POLY;
         end else begin
            c = c >> 1;
         end
      end
      return c;
   endfunction

endpackage

[sv/hdlc_enc_front.sv]
// ---------------------------------------------------------------------------
// HDLC encoder front end
// Accepts frame bytes, keeps the running CRC and, while the queue has room,
// issues one byte unit per cycle: opening flag, data, FCS lo/hi, closing flag.
// ---------------------------------------------------------------------------
module hdlc_enc_front
   import hdlc_enc_pkg::*;
(
   input  logic       clock,
   input  logic       reset,
   input  logic       req_push,
   output logic       req_full,
   input  logic [7:0] req_data_byte,
   input  logic       req_first_of_frame,
   input  logic       req_last_of_frame,
   output logic       seg_push,
   output seg_type    seg_out,
   input  logic       seg_full
);

   front_state_type state_ff, state_in;
   logic [15:0]     crc_ff, crc_in;
   logic [7:0]      data_ff;
   logic            last_ff;
   logic            accept;
   logic            seg_final;

   assign accept = req_push && !req_full;

   // Output decode
   always_comb begin
      seg_push  = (state_ff != FS_IDLE) && !seg_full;
      seg_out   = '0;
      seg_final = 1'b0;
      unique case (state_ff)
         FS_IDLE: begin
            seg_push = 1'b0;
         end
         FS_OPEN: begin
            seg_out.data       = HDLC_FLAG;
            seg_out.is_flag    = 1'b1;
            seg_out.reset_line = 1'b1;
         end
         FS_DATA: begin
            seg_out.data     = data_ff;
            seg_out.end_mark = !last_ff;
            seg_final        = !last_ff;
         end
         FS_FCS_LO: begin
            seg_out.data = ~crc_ff[7:0];
         end
         FS_FCS_HI: begin
            seg_out.data = ~crc_ff[15:8];
         end
         FS_CLOSE: begin
            seg_out.data     = HDLC_FLAG;
            seg_out.is_flag  = 1'b1;
            seg_out.end_mark = 1'b1;
            seg_final        = 1'b1;
         end
         default: begin
            seg_push = 1'b0;
         end
      endcase
      req_full = (state_ff != FS_IDLE) && !(seg_push && seg_final);
   end

   // Next state
   always_comb begin
      state_in = state_ff;
      if (seg_push) begin
         unique case (state_ff)
            FS_OPEN:   state_in = FS_DATA;
            FS_DATA:   state_in = last_ff ? FS_FCS_LO : FS_IDLE;
            FS_FCS_LO: state_in = FS_FCS_HI;
            FS_FCS_HI: state_in = FS_CLOSE;
            FS_CLOSE:  state_in = FS_IDLE;
            default:   state_in = FS_IDLE;
         endcase
      end
      if (accept) begin
         state_in = req_first_of_frame ? FS_OPEN : FS_DATA;
      end
   end

   always_comb begin
      crc_in = crc_ff;
      if (accept) begin
         crc_in = crc_byte(req_first_of_frame ? CRC_INIT : crc_ff, req_data_byte);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= FS_IDLE;
         crc_ff   <= CRC_INIT;
      end else begin
         state_ff <= state_in;
         crc_ff   <= crc_in;
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         data_ff <= req_data_byte;
         last_ff <= req_last_of_frame;
      end
   end

endmodule

[sv/hdlc_enc_queue.sv]
// ---------------------------------------------------------------------------
// HDLC encoder unit queue
// Small register FIFO of byte units between the front and back ends.
// ---------------------------------------------------------------------------
module hdlc_enc_queue
   import hdlc_enc_pkg::*;
#(
   parameter int DEPTH = HDLC_QUEUE_DEPTH
) (
   input  logic    clock,
   input  logic    reset,
   input  logic    push,
   input  seg_type push_data,
   output logic    full,
   input  logic    pop,
   output seg_type pop_data,
   output logic    empty
);

   localparam int PtrW = $clog2(DEPTH);
   localparam int CntW = $clog2(DEPTH + 1);
   localparam logic [PtrW-1:0] LastPtr = PtrW'(DEPTH - 1);

   seg_type             slot_ff [DEPTH];
   logic [PtrW-1:0]     wr_ff, wr_in;
   logic [PtrW-1:0]     rd_ff, rd_in;
   logic [CntW-1:0]     cnt_ff, cnt_in;
   logic                do_push, do_pop;

   assign full     = (cnt_ff == CntW'(DEPTH));
   assign empty    = (cnt_ff == '0);
   assign do_push  = push && !full;
   assign do_pop   = pop && !empty;
   assign pop_data = slot_ff[rd_ff];

   always_comb begin
      wr_in  = wr_ff;
      rd_in  = rd_ff;
      cnt_in = cnt_ff;
      if (do_push) begin
         wr_in = (wr_ff == LastPtr) ? '0 : wr_ff + 1'b1;
      end
      if (do_pop) begin
         rd_in = (rd_ff == LastPtr) ? '0 : rd_ff + 1'b1;
      end
      if (do_push && !do_pop) begin
         cnt_in = cnt_ff + 1'b1;
      end else if (do_pop && !do_push) begin
         cnt_in = cnt_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ff  <= '0;
         rd_ff  <= '0;
         cnt_ff <= '0;
      end else begin
         wr_ff  <= wr_in;
         rd_ff  <= rd_in;
         cnt_ff <= cnt_in;
      end
   end

   always_ff @(posedge clock) begin
      if (do_push) begin
         slot_ff[wr_ff] <= push_data;
      end
   end

endmodule

[sv/hdlc_enc_back.sv]
// ---------------------------------------------------------------------------
// HDLC encoder back end
// Serializes byte units LSB first, inserts stuffed zeros, NRZI codes each
// bit and holds it in the result register.
// ---------------------------------------------------------------------------
module hdlc_enc_back
   import hdlc_enc_pkg::*;
(
   input  logic    clock,
   input  logic    reset,
   input  logic    seg_valid,
   input  seg_type seg_in,
   output logic    seg_pop,
   output logic    rsp_empty,
   input  logic    rsp_pop,
   output logic    rsp_line_level,
   output logic    rsp_raw_bit,
   output logic    rsp_flag_bit,
   output logic    rsp_inserted_zero,
   output logic    rsp_end_of_run
);

   seg_type    seg_ff;
   logic       busy_ff, busy_in;
   logic [2:0] idx_ff, idx_in;
   logic       stuff_ff, stuff_in;
   logic [2:0] ones_ff, ones_in;
   logic       level_ff, level_in;
   logic       out_valid_ff;
   logic       line_ff, raw_ff, flag_ff, ins_ff, end_ff;

   logic       emit_ok, fresh, raw, need_stuff, seg_done, lvl_base, lvl_new;
   logic [2:0] ones_base, ones_new, ones_sum;

   assign emit_ok = busy_ff && (!out_valid_ff || rsp_pop);
   assign fresh   = seg_ff.reset_line && (idx_ff == '0) && !stuff_ff;

   always_comb begin
      ones_base  = fresh ? 3'd0 : ones_ff;
      lvl_base   = fresh ? 1'b1 : level_ff;
      ones_sum   = ones_base + 3'd1;
      need_stuff = 1'b0;
      if (stuff_ff) begin
         raw      = 1'b0;
         ones_new = 3'd0;
      end else begin
         raw = seg_ff.data[idx_ff];
         if (seg_ff.is_flag) begin
            ones_new = ones_base;
         end else if (raw) begin
            need_stuff = (ones_sum >= STUFF_LIMIT);
            ones_new   = need_stuff ? 3'd0 : ones_sum;
         end else begin
            ones_new = 3'd0;
         end
      end
      lvl_new  = raw ? lvl_base : !lvl_base;
      seg_done = !need_stuff && (idx_ff == 3'd7);
   end

   assign seg_pop = seg_valid && (!busy_ff || (emit_ok && seg_done));

   always_comb begin
      busy_in  = busy_ff;
      idx_in   = idx_ff;
      stuff_in = stuff_ff;
      ones_in  = ones_ff;
      level_in = level_ff;
      if (emit_ok) begin
         ones_in  = ones_new;
         level_in = lvl_new;
         stuff_in = need_stuff;
         if (!need_stuff && !seg_done) begin
            idx_in = idx_ff + 3'd1;
         end
         if (seg_done) begin
            busy_in = 1'b0;
         end
      end
      if (seg_pop) begin
         busy_in  = 1'b1;
         idx_in   = '0;
         stuff_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff      <= 1'b0;
         idx_ff       <= '0;
         stuff_ff     <= 1'b0;
         ones_ff      <= '0;
         level_ff     <= 1'b1;
         out_valid_ff <= 1'b0;
      end else begin
         busy_ff  <= busy_in;
         idx_ff   <= idx_in;
         stuff_ff <= stuff_in;
         ones_ff  <= ones_in;
         level_ff <= level_in;
         if (emit_ok) begin
            out_valid_ff <= 1'b1;
         end else if (rsp_pop) begin
            out_valid_ff <= 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (seg_pop) begin
         seg_ff <= seg_in;
      end
      if (emit_ok) begin
         line_ff <= lvl_new;
         raw_ff  <= raw;
         flag_ff <= seg_ff.is_flag;
         ins_ff  <= stuff_ff;
         end_ff  <= seg_ff.end_mark && seg_done;
      end
   end

   assign rsp_empty         = !out_valid_ff;
   assign rsp_line_level    = line_ff;
   assign rsp_raw_bit       = raw_ff;
   assign rsp_flag_bit      = flag_ff;
   assign rsp_inserted_zero = ins_ff;
   assign rsp_end_of_run    = end_ff;

endmodule

[sv/hdlc_frame_bit_encoder_unit.sv]
// ---------------------------------------------------------------------------
// HDLC frame bit encoder
// Frame bytes in, NRZI coded line bits out, with flags, FCS and stuffing.
// ---------------------------------------------------------------------------
// The block delivers one line bit per clock cycle from its result register
// while the bits are popped, so a data byte gives 8 to 10 line bits (8 bits
// plus up to two stuffed zeros); a first-of-frame byte adds 8 bits of opening
// flag and a last-of-frame byte adds 16 to 20 bits of FCS and 8 of closing
// flag. That bit serializer sets the throughput. The front end computes the
// CRC of a byte in the cycle it is accepted and places one byte unit per
// cycle in a short queue while it has room, so the next input byte is taken
// as soon as the units of the current one are queued, while the serializer
// is still sending earlier bits and while a finished bit waits to be popped.
// ---------------------------------------------------------------------------
module hdlc_frame_bit_encoder_unit
   import hdlc_enc_pkg::*;
#(
   parameter int QUEUE_DEPTH = HDLC_QUEUE_DEPTH
) (
   input  logic       clock,
   input  logic       reset,
   input  logic       req_push,
   output logic       req_full,
   input  logic [7:0] req_data_byte,
   input  logic       req_first_of_frame,
   input  logic       req_last_of_frame,
   output logic       rsp_empty,
   input  logic       rsp_pop,
   output logic       rsp_line_level,
   output logic       rsp_raw_bit,
   output logic       rsp_flag_bit,
   output logic       rsp_inserted_zero,
   output logic       rsp_end_of_run
);

   seg_type q_in, q_out;
   logic    q_push, q_full, q_pop, q_empty;

   hdlc_enc_front u_front (
      .clock              (clock),
      .reset              (reset),
      .req_push           (req_push),
      .req_full           (req_full),
      .req_data_byte      (req_data_byte),
      .req_first_of_frame (req_first_of_frame),
      .req_last_of_frame  (req_last_of_frame),
      .seg_push           (q_push),
      .seg_out            (q_in),
      .seg_full           (q_full)
   );

   hdlc_enc_queue #(
      .DEPTH (QUEUE_DEPTH)
   ) u_queue (
      .clock     (clock),
      .reset     (reset),
      .push      (q_push),
      .push_data (q_in),
      .full      (q_full),
      .pop       (q_pop),
      .pop_data  (q_out),
      .empty     (q_empty)
   );

   hdlc_enc_back u_back (
      .clock             (clock),
      .reset             (reset),
      .seg_valid         (!q_empty),
      .seg_in            (q_out),
      .seg_pop           (q_pop),
      .rsp_empty         (rsp_empty),
      .rsp_pop           (rsp_pop),
      .rsp_line_level    (rsp_line_level),
      .rsp_raw_bit       (rsp_raw_bit),
      .rsp_flag_bit      (rsp_flag_bit),
      .rsp_inserted_zero (rsp_inserted_zero),
      .rsp_end_of_run    (rsp_end_of_run)
   );

endmodule
